// ----- sv/dcfp_pkg.sv -----
`timescale 1ns / 1ps

package dcfp_pkg;

  localparam int BUF_BYTES = 768;
  localparam int STORE_DEPTH = 2 * BUF_BYTES;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int POS_W = $clog2(BUF_BYTES + 4);
  localparam int ACC_W = $clog2(BUF_BYTES + 1);

  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_S = 8'h53;

  localparam logic [7:0] BRIGHT_RESET = 8'hff;
  localparam logic [15:0] SPEED_RESET = 16'hffff;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_VALID   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_in;
    logic [9:0] read_addr;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  brightness_level;
    logic [15:0] speed_value;
    logic [9:0]  frame_length;
    logic        shown_bank;
    logic [7:0]  read_data;
  } out_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  brightness_level;
    logic [15:0] speed_value;
    logic [9:0]  frame_length;
    logic        shown_bank;
    logic        read_hit;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

// ----- sv/dcfp_ram.sv -----
`timescale 1ns / 1ps

module dcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dcfp_parser.sv -----
`timescale 1ns / 1ps

module dcfp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  dcfp_pkg::in_t    item,
  output dcfp_pkg::res_t   res,
  output dcfp_pkg::ram_wr_t wr,
  output dcfp_pkg::ram_rd_t rd
);

  typedef enum logic [2:0] {
    KIND_IDLE   = 3'd0,
    KIND_FRAME  = 3'd1,
    KIND_ANIM   = 3'd2,
    KIND_BRIGHT = 3'd3,
    KIND_SPEED  = 3'd4
  } kind_t;

  kind_t                      kind_r, kind_nxt;
  logic [dcfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [dcfp_pkg::POS_W-1:0] decl_r, decl_nxt;
  logic [7:0]                 len_hi_r, len_hi_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic                       wb_r, wb_nxt;
  logic                       disp_r, disp_nxt;
  logic [dcfp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [7:0]                 bright_r, bright_nxt;
  logic [15:0]                speed_r, speed_nxt;
  logic [7:0]                 hold_r, hold_nxt;

  dcfp_pkg::status_t          status;
  logic [15:0]                full_len;
  logic [dcfp_pkg::POS_W-1:0] off;
  logic [7:0]                 want;

  always_comb begin
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    decl_nxt   = decl_r;
    len_hi_nxt = len_hi_r;
    sum_nxt    = sum_r;
    wb_nxt     = wb_r;
    disp_nxt   = disp_r;
    acc_nxt    = acc_r;
    bright_nxt = bright_r;
    speed_nxt  = speed_r;
    hold_nxt   = hold_r;
    status     = dcfp_pkg::ST_BUSY;
    full_len   = {len_hi_r, item.byte_in};
    off        = pos_r - dcfp_pkg::POS_W'(3);
    want       = 8'd0 - sum_r;
    wr.we      = 1'b0;
    wr.addr    = dcfp_pkg::ADDR_W'(int'(off) + (wb_r ? dcfp_pkg::BUF_BYTES : 0));
    wr.data    = item.byte_in;

    if (!item.func) begin
      if (pos_r == '0) begin
        pos_nxt = dcfp_pkg::POS_W'(1);
        unique case (item.byte_in)
          dcfp_pkg::CHAR_F: kind_nxt = KIND_FRAME;
          dcfp_pkg::CHAR_A: kind_nxt = KIND_ANIM;
          dcfp_pkg::CHAR_B: kind_nxt = KIND_BRIGHT;
          dcfp_pkg::CHAR_S: kind_nxt = KIND_SPEED;
          default: begin
            kind_nxt = KIND_IDLE;
            pos_nxt  = '0;
            status   = dcfp_pkg::ST_INVALID;
          end
        endcase
      end else begin
        unique case (kind_r)
          KIND_FRAME: begin
            if (pos_r >= decl_r + dcfp_pkg::POS_W'(4)) begin
              pos_nxt  = '0;
              sum_nxt  = '0;
              decl_nxt = '0;
              kind_nxt = KIND_IDLE;
              if (item.byte_in == want) begin
                disp_nxt = wb_r;
                acc_nxt  = dcfp_pkg::ACC_W'(decl_r + dcfp_pkg::POS_W'(1));
                wb_nxt   = ~wb_r;
                status   = dcfp_pkg::ST_VALID;
              end else begin
                status = dcfp_pkg::ST_INVALID;
              end
            end else begin
              sum_nxt = sum_r + item.byte_in;
              priority if (pos_r == dcfp_pkg::POS_W'(1)) begin
                len_hi_nxt = item.byte_in;
                pos_nxt    = dcfp_pkg::POS_W'(2);
              end else if (pos_r == dcfp_pkg::POS_W'(2)) begin
                if (32'(full_len) >= 32'(dcfp_pkg::BUF_BYTES)) begin
                  decl_nxt = '0;
                  sum_nxt  = '0;
                  pos_nxt  = '0;
                  kind_nxt = KIND_IDLE;
                  status   = dcfp_pkg::ST_INVALID;
                end else begin
                  decl_nxt = dcfp_pkg::POS_W'(full_len);
                  pos_nxt  = dcfp_pkg::POS_W'(3);
                end
              end else begin
                wr.we   = accept;
                pos_nxt = pos_r + dcfp_pkg::POS_W'(1);
              end
            end
          end
          KIND_BRIGHT: begin
            bright_nxt = item.byte_in;
            pos_nxt    = '0;
            kind_nxt   = KIND_IDLE;
            status     = dcfp_pkg::ST_VALID;
          end
          KIND_SPEED: begin
            if (pos_r == dcfp_pkg::POS_W'(1)) begin
              hold_nxt = item.byte_in;
              pos_nxt  = dcfp_pkg::POS_W'(2);
            end else begin
              speed_nxt = {hold_r, item.byte_in};
              pos_nxt   = '0;
              kind_nxt  = KIND_IDLE;
              status    = dcfp_pkg::ST_VALID;
            end
          end
          default: begin
            pos_nxt  = '0;
            kind_nxt = KIND_IDLE;
            status   = dcfp_pkg::ST_INVALID;
          end
        endcase
      end
    end
  end

  always_comb begin
    rd.re   = accept & item.func;
    rd.addr = dcfp_pkg::ADDR_W'(int'(item.read_addr) + (disp_r ? dcfp_pkg::BUF_BYTES : 0));

    res.status           = status;
    res.brightness_level = bright_nxt;
    res.speed_value      = speed_nxt;
    res.frame_length     = 10'(acc_nxt);
    res.shown_bank       = disp_nxt;
    res.read_hit         = item.func && (32'(item.read_addr) < 32'(dcfp_pkg::BUF_BYTES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_IDLE;
      pos_r    <= '0;
      decl_r   <= '0;
      len_hi_r <= '0;
      sum_r    <= '0;
      wb_r     <= 1'b0;
      disp_r   <= 1'b0;
      acc_r    <= '0;
      bright_r <= dcfp_pkg::BRIGHT_RESET;
      speed_r  <= dcfp_pkg::SPEED_RESET;
      hold_r   <= '0;
    end else if (accept) begin
      kind_r   <= kind_nxt;
      pos_r    <= pos_nxt;
      decl_r   <= decl_nxt;
      len_hi_r <= len_hi_nxt;
      sum_r    <= sum_nxt;
      wb_r     <= wb_nxt;
      disp_r   <= disp_nxt;
      acc_r    <= acc_nxt;
      bright_r <= bright_nxt;
      speed_r  <= speed_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

// ----- sv/display_command_frame_parser.sv -----
`timescale 1ns / 1ps

// Parses link bytes into brightness, speed and frame commands and serves reads of the shown
// frame bank. One request is taken every cycle while in_ready is high. Its result passes the
// first stage, which holds the registered read of the frame store RAM (one write and one read
// port), and then the result stage, and is held there until taken. While a result is held, one
// more request is taken into the first stage before in_ready drops. No request is taken during
// reset. The frame store needs no clearing pass after reset, so the block is ready at once.

module display_command_frame_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dcfp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dcfp_pkg::out_t out_data
);

  logic              accept;
  logic              adv;
  dcfp_pkg::res_t    res;
  dcfp_pkg::ram_wr_t wr;
  dcfp_pkg::ram_rd_t rd;
  logic [7:0]        rdata;

  logic              s1_v_r, s1_v_nxt;
  dcfp_pkg::res_t    s1_r;
  logic              out_v_r, out_v_nxt;
  dcfp_pkg::out_t    out_r;

  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = rst_n && (!s1_v_r || adv);
  assign accept   = in_valid && in_ready;

  assign s1_v_nxt  = accept || (s1_v_r && !adv);
  assign out_v_nxt = adv || (out_v_r && !out_ready);

  dcfp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .res    (res),
    .wr     (wr),
    .rd     (rd)
  );

  dcfp_ram #(
    .WIDTH (8),
    .DEPTH (dcfp_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
    if (accept) begin
      s1_r <= res;
    end
    if (adv) begin
      out_r.status           <= s1_r.status;
      out_r.brightness_level <= s1_r.brightness_level;
      out_r.speed_value      <= s1_r.speed_value;
      out_r.frame_length     <= s1_r.frame_length;
      out_r.shown_bank       <= s1_r.shown_bank;
      out_r.read_data        <= s1_r.read_hit ? rdata : 8'd0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted request did not reach the first stage");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("advancing request did not reach the result stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_r)))
    else $error("stalled first stage lost its contents");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && $stable(out_r)))
    else $error("stalled result changed");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |-> !in_ready)
    else $error("request taken while both stages were full");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  typedef enum int {
    K_IDLE,
    K_FRAME,
    K_ANIM,
    K_BRIGHT,
    K_SPEED
  } cmd_kind_t;

  typedef struct packed {
    logic              func;
    logic [7:0]        link_byte;
    logic [9:0]        addr;
    logic              typed;
    dcfp_pkg::status_t st;
    logic [7:0]        bright;
    logic [15:0]       speed;
    logic [9:0]        len;
    logic              bank;
    logic [7:0]        rd;
  } dir_row_t;

  localparam int N_DIRECTED = 27;
  localparam int RANDOM_ITEMS = 460;
  localparam int LONG_HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dcfp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dcfp_pkg::out_t out_data;

  display_command_frame_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 8'h00, 10'd0, 1'b1, dcfp_pkg::ST_INVALID,
      8'hff, 16'hffff, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'hff, 10'h3ff, 1'b1, dcfp_pkg::ST_INVALID,
      8'hff, 16'hffff, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_B, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b1, dcfp_pkg::ST_VALID,
      8'h00, 16'hffff, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_S, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b1, dcfp_pkg::ST_VALID,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_S, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'hff, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'hff, 10'd0, 1'b1, dcfp_pkg::ST_VALID,
      8'h00, 16'hffff, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_A, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_B, 10'd0, 1'b1, dcfp_pkg::ST_INVALID,
      8'h00, 16'hffff, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_F, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h03, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b1, dcfp_pkg::ST_INVALID,
      8'h00, 16'hffff, 10'd0, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_F, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h5a, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'ha6, 10'd0, 1'b1, dcfp_pkg::ST_VALID,
      8'h00, 16'hffff, 10'd1, 1'b0, 8'h00},
    '{1'b1, 8'h00, 10'd0, 1'b1, dcfp_pkg::ST_BUSY,
      8'h00, 16'hffff, 10'd1, 1'b0, 8'h5a},
    '{1'b1, 8'hff, 10'h3ff, 1'b1, dcfp_pkg::ST_BUSY,
      8'h00, 16'hffff, 10'd1, 1'b0, 8'h00},
    '{1'b0, dcfp_pkg::CHAR_F, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h12, 10'd0, 1'b0, dcfp_pkg::ST_BUSY,
      8'h00, 16'h0000, 10'd0, 1'b0, 8'h00},
    '{1'b0, 8'h00, 10'd0, 1'b1, dcfp_pkg::ST_INVALID,
      8'h00, 16'hffff, 10'd1, 1'b0, 8'h00}
  };

  cmd_kind_t cur_kind = K_IDLE;
  int byte_pos = 0;
  int decl_len = 0;
  logic [7:0] chk_sum = 8'h00;
  logic wr_bank = 1'b0;
  logic shown_bank_q = 1'b0;
  int shown_len = 0;
  logic [7:0] bright_q = dcfp_pkg::BRIGHT_RESET;
  logic [15:0] speed_q = dcfp_pkg::SPEED_RESET;
  logic [7:0] speed_hi = 8'h00;
  logic [7:0] frame_mem [dcfp_pkg::STORE_DEPTH];
  bit written [dcfp_pkg::STORE_DEPTH];

  dcfp_pkg::out_t pending_replies [$];
  int requests_sent = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int frames_ok = 0;
  int frames_bad = 0;
  int reads_sent = 0;
  bit sender_rush = 1'b0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  function automatic dcfp_pkg::out_t parser_step(dcfp_pkg::in_t req);
    dcfp_pkg::out_t r;
    logic [7:0] b;
    logic [7:0] want;
    int off;
    b = req.byte_in;
    r.status = dcfp_pkg::ST_BUSY;
    r.read_data = 8'h00;
    if (req.func) begin
      reads_sent++;
      if (int'(req.read_addr) < dcfp_pkg::BUF_BYTES) begin
        r.read_data = frame_mem[int'(shown_bank_q) * dcfp_pkg::BUF_BYTES +
                                int'(req.read_addr)];
      end
    end else if (byte_pos == 0) begin
      case (b)
        dcfp_pkg::CHAR_F: cur_kind = K_FRAME;
        dcfp_pkg::CHAR_A: cur_kind = K_ANIM;
        dcfp_pkg::CHAR_B: cur_kind = K_BRIGHT;
        dcfp_pkg::CHAR_S: cur_kind = K_SPEED;
        default: begin
          cur_kind = K_IDLE;
          r.status = dcfp_pkg::ST_INVALID;
        end
      endcase
      if (r.status == dcfp_pkg::ST_BUSY) byte_pos = 1;
    end else begin
      case (cur_kind)
        K_FRAME: begin
          if (byte_pos >= decl_len + 4) begin
            want = 8'h00 - chk_sum;
            byte_pos = 0;
            chk_sum = 8'h00;
            if (b == want) begin
              shown_bank_q = wr_bank;
              shown_len = decl_len + 1;
              wr_bank = ~wr_bank;
              r.status = dcfp_pkg::ST_VALID;
              frames_ok++;
            end else begin
              r.status = dcfp_pkg::ST_INVALID;
              frames_bad++;
            end
            decl_len = 0;
            cur_kind = K_IDLE;
          end else begin
            chk_sum = chk_sum + b;
            if (byte_pos == 1) begin
              decl_len = int'(b) << 8;
              byte_pos = 2;
            end else if (byte_pos == 2) begin
              decl_len = decl_len | int'(b);
              if (decl_len >= dcfp_pkg::BUF_BYTES) begin
                decl_len = 0;
                chk_sum = 8'h00;
                byte_pos = 0;
                cur_kind = K_IDLE;
                r.status = dcfp_pkg::ST_INVALID;
              end else begin
                byte_pos = 3;
              end
            end else begin
              off = byte_pos - 3;
              if (off < dcfp_pkg::BUF_BYTES) begin
                frame_mem[int'(wr_bank) * dcfp_pkg::BUF_BYTES + off] = b;
                written[int'(wr_bank) * dcfp_pkg::BUF_BYTES + off] = 1'b1;
              end
              byte_pos++;
            end
          end
        end
        K_BRIGHT: begin
          bright_q = b;
          byte_pos = 0;
          cur_kind = K_IDLE;
          r.status = dcfp_pkg::ST_VALID;
        end
        K_SPEED: begin
          if (byte_pos == 1) begin
            speed_hi = b;
            byte_pos = 2;
          end else begin
            byte_pos = 0;
            cur_kind = K_IDLE;
            speed_q = {speed_hi, b};
            r.status = dcfp_pkg::ST_VALID;
          end
        end
        default: begin
          byte_pos = 0;
          cur_kind = K_IDLE;
          r.status = dcfp_pkg::ST_INVALID;
        end
      endcase
    end
    r.brightness_level = bright_q;
    r.speed_value = speed_q;
    r.frame_length = 10'(shown_len);
    r.shown_bank = shown_bank_q;
    return r;
  endfunction

  task automatic send(dcfp_pkg::in_t req, bit typed, dcfp_pkg::out_t typed_reply);
    int gap;
    dcfp_pkg::out_t predicted;
    gap = (sender_rush || long_hold) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    predicted = parser_step(req);
    pending_replies.push_back(typed ? typed_reply : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    dcfp_pkg::in_t req;
    req.func = 1'b0;
    req.byte_in = b;
    req.read_addr = 10'($urandom_range(0, 1023));
    send(req, 1'b0, '0);
  endtask

  task automatic send_read();
    dcfp_pkg::in_t req;
    int sel;
    int a;
    sel = $urandom_range(0, 9);
    if (sel < 4) a = $urandom_range(0, (shown_len > 0) ? shown_len - 1 : 0);
    else if (sel < 8) a = $urandom_range(0, dcfp_pkg::BUF_BYTES - 1);
    else a = $urandom_range(dcfp_pkg::BUF_BYTES, 1023);
    if (a < dcfp_pkg::BUF_BYTES &&
        !written[int'(shown_bank_q) * dcfp_pkg::BUF_BYTES + a]) begin
      if (shown_len > 0) a = $urandom_range(0, shown_len - 1);
      else a = $urandom_range(dcfp_pkg::BUF_BYTES, 1023);
    end
    req.func = 1'b1;
    req.byte_in = 8'($urandom_range(0, 255));
    req.read_addr = 10'(a);
    send(req, 1'b0, '0);
  endtask

  task automatic send_frame(int len_m1, bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'(len_m1 >> 8) + 8'(len_m1);
    send_byte(dcfp_pkg::CHAR_F);
    send_byte(8'(len_m1 >> 8));
    send_byte(8'(len_m1));
    for (int i = 0; i <= len_m1; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    if (good_sum) send_byte(8'h00 - sum);
    else send_byte(8'h00 - sum + 8'($urandom_range(1, 255)));
  endtask

  task automatic random_command();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    sender_rush = ($urandom_range(0, 4) == 0);
    if (pick < 35) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 80) : $urandom_range(0, 15);
      send_frame(n, $urandom_range(0, 4) != 0);
    end else if (pick < 50) begin
      send_byte(dcfp_pkg::CHAR_B);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      send_byte(dcfp_pkg::CHAR_S);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 83) begin
      n = $urandom_range(1, 3);
      repeat (n) send_read();
    end else if (pick < 88) begin
      send_byte(dcfp_pkg::CHAR_A);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      send_byte(dcfp_pkg::CHAR_F);
      send_byte(8'($urandom_range(3, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    dcfp_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %p", $realtime, out_data);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.status !== want.status ||
            out_data.brightness_level !== want.brightness_level ||
            out_data.speed_value !== want.speed_value ||
            out_data.frame_length !== want.frame_length ||
            out_data.shown_bank !== want.shown_bank ||
            out_data.read_data !== want.read_data) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d expected %p", $realtime, replies_seen, want);
            $display("%0t: result %0d got      %p", $realtime, replies_seen, out_data);
          end
        end
      end
    end
  end

  initial begin
    int stall;
    int streak;
    bit rx_rush;
    streak = 0;
    rx_rush = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (streak == 0) begin
        streak = $urandom_range(5, 30);
        rx_rush = ($urandom_range(0, 3) == 0);
      end
      streak--;
      if (!hold_done && replies_seen >= 150) begin
        hold_done = 1'b1;
        long_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        stall = rx_rush ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    dcfp_pkg::in_t req;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      req.func = directed_rows[i].func;
      req.byte_in = directed_rows[i].link_byte;
      req.read_addr = directed_rows[i].addr;
      send(req, directed_rows[i].typed,
           '{directed_rows[i].st, directed_rows[i].bright, directed_rows[i].speed,
             directed_rows[i].len, directed_rows[i].bank, directed_rows[i].rd});
    end
    while (requests_sent < N_DIRECTED + RANDOM_ITEMS) random_command();
    sender_rush = 1'b0;
    repeat (12) send_read();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d requests, %0d of them reads.",
             replies_seen, requests_sent, reads_sent);
    $display("Frames: %0d accepted, %0d rejected on checksum; %0d mismatches.",
             frames_ok, frames_bad, mismatches);
    if (mismatches == 0) begin
      $display("display_command_frame_parser: match");
    end else begin
      $display("display_command_frame_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("display_command_frame_parser: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dcfp_pkg.sv
sv/dcfp_ram.sv
sv/dcfp_parser.sv
sv/display_command_frame_parser.sv
dv/testbench.sv
